@@ hdl/aes_cfb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES CFB package
// Shared types, the S-box table and the round functions of the cipher core.
// ----------------------------------------------------------------------------
package aes_cfb_pkg;

	// Round key memory geometry: one 128-bit row per round, 15 rows at most.
	localparam int RK_ROWS = 15;
	localparam int RK_AW   = 4;

	// Configuration register indexes.
	localparam logic [3:0] REG_KEY0   = 4'd0;
	localparam logic [3:0] REG_KEY1   = 4'd1;
	localparam logic [3:0] REG_KEY2   = 4'd2;
	localparam logic [3:0] REG_KEY3   = 4'd3;
	localparam logic [3:0] REG_KLEN   = 4'd4;
	localparam logic [3:0] REG_IV_HI  = 4'd5;
	localparam logic [3:0] REG_IV_LO  = 4'd6;
	localparam logic [3:0] REG_DECRYPT = 4'd7;

	// Key length codes.
	localparam logic [1:0] KLEN_128 = 2'd0;
	localparam logic [1:0] KLEN_192 = 2'd1;
	localparam logic [1:0] KLEN_256 = 2'd2;
	localparam logic [1:0] KLEN_ALT = 2'd3;

	// Round key memory write port.
	typedef struct packed {
		logic              en;
		logic [RK_AW-1:0]  addr;
		logic [127:0]      data;
	} rk_wr_t;

	// Round key memory read port.
	typedef struct packed {
		logic              en;
		logic [RK_AW-1:0]  addr;
	} rk_rd_t;

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	// Multiply by two in GF(2^8).
	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// S-box applied to each byte of a word.
	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// One cipher round without the key addition. Byte k of the state sits
	// at bits 127-8k down; bytes are column major.
	function automatic logic [127:0] aes_round(input logic [127:0] st, input logic final_rnd);
		logic [7:0] sb [16];
		logic [7:0] t  [16];
		logic [7:0] a0, a1, a2, a3;
		logic [127:0] res;
		for (int k = 0; k < 16; k++) begin
			sb[k] = SBOX[st[127-8*k -: 8]];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[4*c+r] = sb[4*((c+r)%4)+r];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c];
			a1 = t[4*c+1];
			a2 = t[4*c+2];
			a3 = t[4*c+3];
			if (final_rnd) begin
				res[127-32*c -: 32] = {a0, a1, a2, a3};
			end else begin
				res[127-32*c -: 32] = {
					xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
					a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
					a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
					xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
			end
		end
		aes_round = res;
	endfunction

endpackage

@@ hdl/aes_cfb_rkmem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES CFB round key memory
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module aes_cfb_rkmem (
	input  logic                   clk,
	input  aes_cfb_pkg::rk_wr_t    wr,
	input  aes_cfb_pkg::rk_rd_t    rd,
	output logic [127:0]           rd_data
);

	logic [127:0] mem [aes_cfb_pkg::RK_ROWS];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

@@ hdl/aes_cfb_keyexp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES CFB key expansion
// Produces one round key word per cycle and writes a memory row every
// fourth word.
// ----------------------------------------------------------------------------
module aes_cfb_keyexp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [255:0]           key,
	input  logic [1:0]             klen,
	output aes_cfb_pkg::rk_wr_t    wr,
	output logic                   done
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  i_q;
	logic [2:0]  mod_q;
	logic [7:0]  rcon_q;
	logic [31:0] win_q [8];
	logic [127:0] row_q;

	logic [3:0]  nk;
	logic [5:0]  last_idx;
	logic [31:0] kword;
	logic [31:0] tmp;
	logic [31:0] new_word;
	logic [127:0] row_next;
	logic        from_key;

	// Next word of the schedule.
	always_comb begin
		nk       = 4'd4 + {1'b0, klen, 1'b0};
		last_idx = 6'(4 * ({2'b00, nk} + 6'd7) - 1);
		from_key = (i_q < {2'b00, nk});
		kword    = key[255 - 32*i_q[2:0] -: 32];
		tmp      = win_q[0];
		if (mod_q == 3'd0) begin
			tmp = aes_cfb_pkg::sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rcon_q, 24'h0};
		end else if (nk == 4'd8 && mod_q == 3'd4) begin
			tmp = aes_cfb_pkg::sub_word(win_q[0]);
		end
		new_word = from_key ? kword : (win_q[3'(nk - 4'd1)] ^ tmp);
		row_next = row_q;
		row_next[127 - 32*i_q[1:0] -: 32] = new_word;
	end

	assign wr.en   = busy_q && (i_q[1:0] == 2'd3);
	assign wr.addr = i_q[5:2];
	assign wr.data = row_next;
	assign done    = done_q;

	// Control of the schedule walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
			mod_q  <= '0;
			rcon_q <= 8'h01;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				mod_q  <= '0;
				rcon_q <= 8'h01;
			end else if (busy_q) begin
				i_q   <= i_q + 6'd1;
				mod_q <= (mod_q == 3'(nk - 4'd1)) ? 3'd0 : mod_q + 3'd1;
				if (!from_key && mod_q == 3'd0) begin
					rcon_q <= aes_cfb_pkg::xtime(rcon_q);
				end
				if (i_q == last_idx) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Window of the last eight words and the row under assembly.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			win_q[0] <= new_word;
			for (int k = 1; k < 8; k++) begin
				win_q[k] <= win_q[k-1];
			end
			row_q <= row_next;
		end
	end

endmodule

@@ hdl/aes_cfb_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES CFB round engine
// Enciphers the feedback block one round per cycle, reading one round key
// row from memory ahead of each round.
// ----------------------------------------------------------------------------
module aes_cfb_engine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [127:0]           fb,
	input  logic [1:0]             klen,
	input  logic [127:0]           rk_data,
	output aes_cfb_pkg::rk_rd_t    rd,
	output logic [127:0]           ks,
	output logic                   done
);

	logic         busy_q;
	logic         done_q;
	logic [3:0]   rnd_q;
	logic [127:0] st_q;
	logic [3:0]   nr;
	logic         last_rnd;

	assign nr       = 4'd10 + {1'b0, klen, 1'b0};
	assign last_rnd = (rnd_q == nr);

	// Fetch the key row for the round after the current one.
	assign rd.en   = start || (busy_q && !last_rnd);
	assign rd.addr = start ? '0 : rnd_q + 4'd1;
	assign ks      = st_q;
	assign done    = done_q;

	// Round sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 4'd1;
				if (last_rnd) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Cipher state: initial key addition, then the rounds, the last one without MixColumns.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (rnd_q == 4'd0) begin
				st_q <= fb ^ rk_data;
			end else begin
				st_q <= aes_cfb_pkg::aes_round(st_q, last_rnd) ^ rk_data;
			end
		end
	end

endmodule

@@ hdl/aes_cfb_byte_stream_cipher_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES CFB-128 byte stream cipher core
// Each accepted input byte is XORed with its keystream byte and registered for output.
// Each 16-byte block first needs its keystream from the one-round-per-cycle
// engine fed by the round key memory; no input is taken meanwhile.
// After a key or key length write, key expansion runs before the keystream.
// Reset clears the control state and the configuration registers; the IV,
// and so the feedback, reset to zero.
// ----------------------------------------------------------------------------
module aes_cfb_byte_stream_cipher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_in
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] data_out
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_EXPAND, ST_CIPHER} state_t;

	state_t       state_q;
	logic         kx_start_q;
	logic         eng_start_q;
	logic         keys_exp_q;
	logic         ks_valid_q;
	logic [3:0]   pos_q;
	logic [63:0]  key_q [4];
	logic [1:0]   klen_q;
	logic [63:0]  iv_hi_q;
	logic [63:0]  iv_lo_q;
	logic         decrypt_q;
	logic [127:0] fb_q;
	logic [7:0]   gather_q [16];
	logic         m_valid_q;
	logic [7:0]   m_data_q;
	logic         m_last_q;

	aes_cfb_pkg::rk_wr_t rk_wr;
	aes_cfb_pkg::rk_rd_t rk_rd;
	logic [127:0] rk_data;
	logic [127:0] ks;
	logic         kx_done;
	logic         eng_done;

	logic         s_fire;
	logic         cfg_fire;
	logic         cfg_hit;
	logic [7:0]   out_byte;
	logic [7:0]   ct_byte;
	logic [127:0] gather_full;

	aes_cfb_keyexp u_keyexp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (kx_start_q),
		.key    ({key_q[0], key_q[1], key_q[2], key_q[3]}),
		.klen   (klen_q),
		.wr     (rk_wr),
		.done   (kx_done)
	);

	aes_cfb_rkmem u_rkmem (
		.clk     (clk),
		.wr      (rk_wr),
		.rd      (rk_rd),
		.rd_data (rk_data)
	);

	aes_cfb_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (eng_start_q),
		.fb      (fb_q),
		.klen    (klen_q),
		.rk_data (rk_data),
		.rd      (rk_rd),
		.ks      (ks),
		.done    (eng_done)
	);

	// Handshakes.
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_fire && (cfg_index <= aes_cfb_pkg::REG_DECRYPT);
	assign s_tready  = (state_q == ST_IDLE) && ks_valid_q && !cfg_valid &&
	                   (!m_valid_q || m_tready);
	assign s_fire    = s_tvalid && s_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign m_tlast   = m_last_q;

	// Output byte and the ciphertext byte that feeds back.
	always_comb begin
		out_byte = s_tdata ^ ks[127 - 8*pos_q -: 8];
		ct_byte  = decrypt_q ? s_tdata : out_byte;
		for (int k = 0; k < 15; k++) begin
			gather_full[127 - 8*k -: 8] = gather_q[k];
		end
		gather_full[7:0] = ct_byte;
	end

	// Sequencer: key expansion and keystream generation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kx_start_q  <= 1'b0;
			eng_start_q <= 1'b0;
		end else begin
			kx_start_q  <= 1'b0;
			eng_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!ks_valid_q && !cfg_valid) begin
						if (keys_exp_q) begin
							eng_start_q <= 1'b1;
							state_q     <= ST_CIPHER;
						end else begin
							kx_start_q <= 1'b1;
							state_q    <= ST_EXPAND;
						end
					end
				end
				ST_EXPAND: begin
					if (kx_done) begin
						eng_start_q <= 1'b1;
						state_q     <= ST_CIPHER;
					end
				end
				ST_CIPHER: begin
					if (eng_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Configuration, feedback and stream control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				key_q[k] <= '0;
			end
			klen_q     <= aes_cfb_pkg::KLEN_128;
			iv_hi_q    <= '0;
			iv_lo_q    <= '0;
			decrypt_q  <= 1'b0;
			fb_q       <= '0;
			keys_exp_q <= 1'b0;
			ks_valid_q <= 1'b0;
			pos_q      <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (kx_done) begin
				keys_exp_q <= 1'b1;
			end
			if (eng_done) begin
				ks_valid_q <= 1'b1;
			end
			if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_hit) begin
				pos_q      <= '0;
				ks_valid_q <= 1'b0;
				fb_q       <= {iv_hi_q, iv_lo_q};
				case (cfg_index)
					aes_cfb_pkg::REG_KEY0, aes_cfb_pkg::REG_KEY1,
					aes_cfb_pkg::REG_KEY2, aes_cfb_pkg::REG_KEY3: begin
						key_q[cfg_index[1:0]] <= cfg_data;
						keys_exp_q            <= 1'b0;
					end
					aes_cfb_pkg::REG_KLEN: begin
						klen_q     <= (cfg_data[1:0] == aes_cfb_pkg::KLEN_ALT) ?
						              aes_cfb_pkg::KLEN_256 : cfg_data[1:0];
						keys_exp_q <= 1'b0;
					end
					aes_cfb_pkg::REG_IV_HI: begin
						iv_hi_q <= cfg_data;
						fb_q    <= {cfg_data, iv_lo_q};
					end
					aes_cfb_pkg::REG_IV_LO: begin
						iv_lo_q <= cfg_data;
						fb_q    <= {iv_hi_q, cfg_data};
					end
					default: begin
						decrypt_q <= cfg_data[0];
					end
				endcase
			end else if (s_fire) begin
				m_valid_q <= 1'b1;
				pos_q     <= pos_q + 4'd1;
				if (s_tlast) begin
					pos_q      <= '0;
					ks_valid_q <= 1'b0;
					fb_q       <= {iv_hi_q, iv_lo_q};
				end else if (pos_q == 4'd15) begin
					ks_valid_q <= 1'b0;
					fb_q       <= gather_full;
				end
			end
		end
	end

	// Output beat payload and ciphertext gather.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			m_data_q         <= out_byte;
			m_last_q         <= s_tlast;
			gather_q[pos_q]  <= ct_byte;
		end
	end

	a_accept_needs_keys: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |-> (keys_exp_q && ks_valid_q && state_q == ST_IDLE))
		else $error("input beat accepted without a ready keystream");

	a_engine_needs_keys: assert property (@(posedge clk) disable iff (!arst_n)
		eng_start_q |-> keys_exp_q)
		else $error("cipher started before key expansion finished");

	a_block_end_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && (s_tlast || pos_q == 4'd15)) |=> (!ks_valid_q && pos_q == 4'd0))
		else $error("keystream not refreshed at a block end");

	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> (!ks_valid_q && pos_q == 4'd0))
		else $error("register write did not restart the message");

endmodule

@@ tb/sv/tb_aes_cfb_byte_stream_cipher_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the AES CFB-128 byte stream cipher core
// Streams directed and random messages through the core under several keys,
// key lengths, IVs and directions, predicts every output byte with a
// behavioral AES-CFB model kept in the bench, and compares the outputs beat
// by beat. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_aes_cfb_byte_stream_cipher_core;

	// Register index past the end of the register list.
	localparam logic [3:0] REG_UNUSED_IDX = 4'd9;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic [63:0] cfg_data;

	aes_cfb_byte_stream_cipher_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [7:0] data_in
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [7:0] data_out
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor state: configuration copy and cipher state.
	logic [63:0] key_regs [4];
	logic [1:0]  key_len;
	logic [63:0] iv_hi, iv_lo;
	logic        decrypting;
	logic [7:0]  feedback [16];
	logic [7:0]  keystream [16];
	logic [7:0]  gathered [16];
	logic [3:0]  position;
	logic [31:0] round_keys [60];
	logic        keys_ready;
	int          num_rounds;

	byte_beat_t  pending_beats [$];
	byte_beat_t  expected_bytes [$];
	int          errors;
	bit          quiet_mode;
	bit          hold_sender;

	// GF(2^8) multiply.
	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return r;
	endfunction

	// S-box computed from the field inverse and the affine map.
	function automatic logic [7:0] sbox_calc(input logic [7:0] x);
		logic [7:0] inv, p, res;
		inv = 8'h01;
		p = x;
		for (int e = 0; e < 8; e++) begin
			if (8'd254 >> e & 1) inv = gmul(inv, p);
			p = gmul(p, p);
		end
		res = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
			^ {inv[3:0], inv[7:4]} ^ 8'h63;
		return res;
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] w);
		return {sbox_calc(w[31:24]), sbox_calc(w[23:16]), sbox_calc(w[15:8]),
			sbox_calc(w[7:0])};
	endfunction

	task automatic reload_iv();
		for (int i = 0; i < 8; i++) begin
			feedback[i]     = iv_hi[63-8*i -: 8];
			feedback[8 + i] = iv_lo[63-8*i -: 8];
		end
	endtask

	task automatic expand_round_keys();
		int nk;
		int total;
		logic [7:0]  rc;
		logic [31:0] t;
		logic [7:0]  b;
		nk = (key_len == aes_cfb_pkg::KLEN_128) ? 4 :
			(key_len == aes_cfb_pkg::KLEN_192) ? 6 : 8;
		num_rounds = nk + 6;
		total = 4 * (num_rounds + 1);
		rc = 8'h01;
		t = '0;
		for (int i = 0; i < nk; i++) begin
			for (int j = 0; j < 4; j++) begin
				b = key_regs[(4*i+j) / 8][63 - 8*((4*i+j) % 8) -: 8];
				t = {t[23:0], b};
			end
			round_keys[i] = t;
		end
		for (int i = nk; i < total; i++) begin
			t = round_keys[i-1];
			if (i % nk == 0) begin
				t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = gmul(rc, 8'h02);
			end else if (nk > 6 && i % nk == 4) begin
				t = sbox_word(t);
			end
			round_keys[i] = round_keys[i-nk] ^ t;
		end
		keys_ready = 1'b1;
	endtask

	task automatic add_key(inout logic [7:0] s [16], input int rnd);
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				s[4*c+r] ^= round_keys[4*rnd+c][31-8*r -: 8];
	endtask

	// Encipher the feedback block into the keystream.
	task automatic make_keystream();
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3;
		s = feedback;
		add_key(s, 0);
		for (int rnd = 1; rnd <= num_rounds; rnd++) begin
			for (int i = 0; i < 16; i++) s[i] = sbox_calc(s[i]);
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t[4*c+r] = s[4*((c+r)%4)+r];
			if (rnd != num_rounds) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					s[4*c]   = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
					s[4*c+1] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
					s[4*c+2] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
					s[4*c+3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
				end
			end else begin
				s = t;
			end
			add_key(s, rnd);
		end
		keystream = s;
	endtask

	// Register write as seen by the predictor.
	task automatic apply_register(input logic [3:0] idx, input logic [63:0] val);
		case (idx)
			aes_cfb_pkg::REG_KEY0, aes_cfb_pkg::REG_KEY1,
			aes_cfb_pkg::REG_KEY2, aes_cfb_pkg::REG_KEY3: begin
				key_regs[idx[1:0]] = val;
				keys_ready = 1'b0;
			end
			aes_cfb_pkg::REG_KLEN: begin
				key_len = (val[1:0] == aes_cfb_pkg::KLEN_ALT) ?
					aes_cfb_pkg::KLEN_256 : val[1:0];
				keys_ready = 1'b0;
			end
			aes_cfb_pkg::REG_IV_HI: iv_hi = val;
			aes_cfb_pkg::REG_IV_LO: iv_lo = val;
			aes_cfb_pkg::REG_DECRYPT: decrypting = val[0];
			default: return;
		endcase
		position = '0;
		reload_iv();
	endtask

	// Expected output for one accepted byte.
	task automatic predict_cipher_byte(input byte_beat_t in_beat);
		byte_beat_t o;
		if (position == 0) begin
			if (!keys_ready) expand_round_keys();
			make_keystream();
		end
		o.data = in_beat.data ^ keystream[position];
		o.last = in_beat.last;
		gathered[position] = decrypting ? in_beat.data : o.data;
		if (in_beat.last) begin
			reload_iv();
			position = '0;
		end else if (position == 4'd15) begin
			feedback = gathered;
			position = '0;
		end else begin
			position = position + 4'd1;
		end
		expected_bytes.push_back(o);
	endtask

	// Clock.
	initial clk = 0;
	always #5 clk = ~clk;

	// Run limit.
	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	// Stream driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata  <= 0;
			s_tlast  <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_cipher_byte('{data: s_tdata, last: s_tlast});
			if (!(s_tvalid && !s_tready)) begin
				if (pending_beats.size() > 0 && !hold_sender
					&& (quiet_mode || $urandom_range(99) >= 24)) begin
					s_tvalid <= 1;
					{s_tdata, s_tlast} <= pending_beats.pop_front();
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// Output monitor and receiver stalls.
	always @(posedge clk or negedge arst_n) begin
		byte_beat_t exp_b;
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected output beat data=%h last=%b", m_tdata, m_tlast);
					errors++;
				end else begin
					exp_b = expected_bytes.pop_front();
					if (m_tdata !== exp_b.data) begin
						$error("data_out expected %h actual %h", exp_b.data, m_tdata);
						errors++;
					end
					if (m_tlast !== exp_b.last) begin
						$error("last_out expected %b actual %b", exp_b.last, m_tlast);
						errors++;
					end
				end
			end
			m_tready <= quiet_mode || $urandom_range(99) >= 24;
		end
	end

	task automatic write_register(input logic [3:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, val);
		cfg_valid <= 0;
	endtask

	task automatic wait_drained();
		while (pending_beats.size() > 0 || s_tvalid || expected_bytes.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Random message of the given length; callers mostly pick short ones.
	task automatic queue_message(input int len);
		for (int i = 0; i < len; i++)
			pending_beats.push_back('{data: 8'($urandom_range(255)), last: i == len - 1});
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic random_setup(input logic [1:0] klen);
		for (int i = 0; i < 4; i++)
			write_register(4'(aes_cfb_pkg::REG_KEY0 + i), rand64());
		write_register(aes_cfb_pkg::REG_KLEN, 64'(klen));
		write_register(aes_cfb_pkg::REG_IV_HI, rand64());
		write_register(aes_cfb_pkg::REG_IV_LO, rand64());
		write_register(aes_cfb_pkg::REG_DECRYPT, 64'($urandom_range(1)));
	endtask

	initial begin
		int sent;
		int tail;
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		errors = 0;
		quiet_mode = 0;
		hold_sender = 0;
		for (int i = 0; i < 4; i++) key_regs[i] = 0;
		key_len = aes_cfb_pkg::KLEN_128;
		iv_hi = 0;
		iv_lo = 0;
		decrypting = 0;
		position = 0;
		keys_ready = 0;
		num_rounds = 10;
		reload_iv();
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// Directed: all-zero key and IV straight from reset, extreme bytes,
		// a full block rolling into the next, a one-byte message.
		pending_beats.push_back('{data: 8'h00, last: 0});
		pending_beats.push_back('{data: 8'hff, last: 0});
		for (int i = 0; i < 16; i++)
			pending_beats.push_back('{data: (i % 2) ? 8'hff : 8'h00, last: 0});
		pending_beats.push_back('{data: 8'h5a, last: 1});
		pending_beats.push_back('{data: 8'hff, last: 1});
		wait_drained();

		// All-ones key and IV, AES-256 through the alternate code, decrypting.
		for (int i = 0; i < 4; i++) write_register(4'(aes_cfb_pkg::REG_KEY0 + i), '1);
		write_register(aes_cfb_pkg::REG_KLEN, 64'(aes_cfb_pkg::KLEN_ALT));
		write_register(aes_cfb_pkg::REG_IV_HI, '1);
		write_register(aes_cfb_pkg::REG_IV_LO, '1);
		write_register(aes_cfb_pkg::REG_DECRYPT, 64'd1);
		write_register(REG_UNUSED_IDX, rand64());
		queue_message(20);
		wait_drained();

		// Random phases over every key length, each with a random direction.
		sent = 0;
		for (int ph = 0; sent < 1400; ph++) begin
			random_setup(2'(ph % 4));
			quiet_mode = (ph == 3);
			for (int m = 0; m < 6; m++) begin
				int len;
				len = ($urandom_range(9) == 0) ? $urandom_range(60, 33)
					: $urandom_range(20, 1);
				queue_message(len);
				sent += len;
				// The sender waits for everything in flight once.
				if (ph == 1 && m == 2) begin
					while (pending_beats.size() > 0 || s_tvalid) @(posedge clk);
					hold_sender = 1;
					while (expected_bytes.size() > 0) @(posedge clk);
					hold_sender = 0;
				end
			end
			// Unterminated tail, then a register write starts a new message.
			tail = $urandom_range(15, 1);
			queue_message(tail);
			sent += tail;
			pending_beats[$].last = 0;
			wait_drained();
			quiet_mode = 0;
		end

		wait_drained();
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
